FILE: design/itoa_pkg.sv
// shared types, constants and helpers of the integer to ascii formatter
package itoa_pkg;

    localparam int MAG_W         = 64;
    localparam int DEC_DIGITS    = 20;
    localparam int NDIG_W        = 5;
    localparam int BITS_PER_STEP = 4;
    localparam int STEPS         = MAG_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(STEPS);

    localparam logic [1:0] CMD_SDEC = 2'd0;
    localparam logic [1:0] CMD_UDEC = 2'd1;
    localparam logic [1:0] CMD_HEX  = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [NDIG_W-1:0] HEX_LONG_DIGITS  = 5'd16;
    localparam logic [NDIG_W-1:0] HEX_SHORT_DIGITS = 5'd8;

    typedef logic [DEC_DIGITS-1:0][3:0] digits_t;

    // classified item between front and converter
    typedef struct packed {
        logic             hex;
        logic             wide;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } job_t;

    // converted item between converter and character emitter
    typedef struct packed {
        logic              hex;
        logic              neg;
        logic [NDIG_W-1:0] ndig;
        digits_t           digits;
    } conv_t;

    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] g;
        if (d < 4'd10) begin
            g = CH_ZERO + {4'b0, d};
        end else begin
            g = CH_A + {4'b0, d} - 8'd10;
        end
        return g;
    endfunction

endpackage

FILE: design/itoa_front.sv
// front end: accepts words, drops unused commands, forms sign and magnitude
module itoa_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // value
    input  logic [2:0]           s_tuser,   // command[1:0], long_arg[2]
    output logic                 push_valid,
    output itoa_pkg::job_t       push_job,
    input  logic                 push_ready
);
    import itoa_pkg::*;

    logic [1:0]       cmd;
    logic             wide;
    logic [MAG_W-1:0] sext;
    logic             keep;

    assign cmd      = s_tuser[1:0];
    assign wide     = s_tuser[2];
    assign s_tready = push_ready;

    // short arguments are sign extended for both decimal modes
    assign sext = wide ? s_tdata : {{32{s_tdata[31]}}, s_tdata[31:0]};

    always_comb begin
        keep          = 1'b1;
        push_job.hex  = 1'b0;
        push_job.wide = wide;
        push_job.neg  = 1'b0;
        push_job.mag  = sext;
        unique case (cmd)
            CMD_SDEC: begin
                push_job.neg = sext[MAG_W-1];
                push_job.mag = sext[MAG_W-1] ? (~sext + 64'd1) : sext;
            end
            CMD_UDEC: begin
                push_job.mag = sext;
            end
            CMD_HEX: begin
                push_job.hex = 1'b1;
                push_job.mag = wide ? s_tdata : {32'b0, s_tdata[31:0]};
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign push_valid = s_tvalid && push_ready && keep;

endmodule

FILE: design/itoa_fifo.sv
// short queue between front end and converter
module itoa_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    input  itoa_pkg::job_t push_job,
    output logic           push_ready,
    output logic           pop_valid,
    output itoa_pkg::job_t pop_job,
    input  logic           pop_ready
);
    import itoa_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push;
    logic          pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // the front end only offers a word when the queue has room
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> push_ready)
        else $error("queue written while full");

endmodule

FILE: design/itoa_conv.sv
// converter: binary to bcd by shift and add-3, four bits per cycle; hex words bypass it
module itoa_conv (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  itoa_pkg::job_t  in_job,
    output logic            in_ready,
    output logic            out_valid,
    output itoa_pkg::conv_t out_res,
    input  logic            out_ready
);
    import itoa_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_COUNT, ST_HOLD} state_t;

    state_t            state_reg;
    logic [MAG_W-1:0]  bin_reg;
    digits_t           bcd_reg;
    logic [STEP_W-1:0] step_reg;
    logic              hex_reg;
    logic              neg_reg;
    logic [NDIG_W-1:0] ndig_reg;

    digits_t           bcd_next;
    logic [MAG_W-1:0]  bin_next;
    logic [NDIG_W-1:0] ndig_next;
    logic              dec_ok;

    assign in_ready       = state_reg == ST_IDLE;
    assign out_valid      = state_reg == ST_HOLD;
    assign out_res.hex    = hex_reg;
    assign out_res.neg    = neg_reg;
    assign out_res.ndig   = ndig_reg;
    assign out_res.digits = bcd_reg;

    always_comb begin
        bcd_next = bcd_reg;
        bin_next = bin_reg;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < DEC_DIGITS; d++) begin
                if (bcd_next[d] >= 4'd5) begin
                    bcd_next[d] = bcd_next[d] + 4'd3;
                end
            end
            {bcd_next, bin_next} = {bcd_next, bin_next} << 1;
        end
    end

    // highest nonzero digit sets the length, zero still prints one digit
    always_comb begin
        ndig_next = NDIG_W'(1);
        dec_ok    = 1'b1;
        for (int d = 0; d < DEC_DIGITS; d++) begin
            if (bcd_reg[d] != 4'd0) begin
                ndig_next = NDIG_W'(d + 1);
            end
            if (bcd_reg[d] > 4'd9) begin
                dec_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        hex_reg <= in_job.hex;
                        neg_reg <= in_job.neg;
                        if (in_job.hex) begin
                            bcd_reg   <= digits_t'({{(DEC_DIGITS * 4 - MAG_W){1'b0}},
                                                    in_job.mag});
                            ndig_reg  <= in_job.wide ? HEX_LONG_DIGITS : HEX_SHORT_DIGITS;
                            state_reg <= ST_HOLD;
                        end else begin
                            bin_reg   <= in_job.mag;
                            bcd_reg   <= '0;
                            step_reg  <= '0;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    bcd_reg  <= bcd_next;
                    bin_reg  <= bin_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(STEPS - 1)) begin
                        state_reg <= ST_COUNT;
                    end
                end
                ST_COUNT: begin
                    ndig_reg  <= ndig_next;
                    state_reg <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (out_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_bcd_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD && !hex_reg) |-> dec_ok)
        else $error("decimal result holds a digit above nine");

    a_ndig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_HOLD |-> (ndig_reg != '0 && ndig_reg <= NDIG_W'(DEC_DIGITS)))
        else $error("digit count out of range");

endmodule

FILE: design/itoa_emit.sv
// back end: prefix and digit serializer with output register
module itoa_emit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  itoa_pkg::conv_t in_res,
    output logic            in_ready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // char_out
    output logic            m_tlast
);
    import itoa_pkg::*;

    logic              busy_reg;
    logic [1:0]        pre_reg;    // prefix characters still to send
    logic [NDIG_W-1:0] idx_reg;
    logic              hex_reg;
    digits_t           digits_reg;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    logic              m_tlast_reg;

    logic              advance;
    logic              is_last;
    logic              finish;
    logic              load;
    logic [7:0]        ch;

    assign advance  = busy_reg && (!m_tvalid_reg || m_tready);
    assign is_last  = pre_reg == 2'd0 && idx_reg == '0;
    assign finish   = advance && is_last;
    assign in_ready = !busy_reg || finish;
    assign load     = in_valid && in_ready;

    always_comb begin
        if (pre_reg == 2'd2) begin
            ch = CH_ZERO;
        end else if (pre_reg == 2'd1) begin
            ch = hex_reg ? CH_X : CH_MINUS;
        end else begin
            ch = glyph(digits_reg[idx_reg]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (advance) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= ch;
                m_tlast_reg  <= is_last;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // next conversion loads in the cycle its predecessor sends its last word
            if (load) begin
                busy_reg   <= 1'b1;
                hex_reg    <= in_res.hex;
                pre_reg    <= in_res.hex ? 2'd2 : (in_res.neg ? 2'd1 : 2'd0);
                idx_reg    <= in_res.ndig - 1'b1;
                digits_reg <= in_res.digits;
            end else if (advance) begin
                if (pre_reg != 2'd0) begin
                    pre_reg <= pre_reg - 1'b1;
                end else begin
                    idx_reg <= idx_reg - 1'b1;
                end
                if (is_last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (busy_reg && (pre_reg != 2'd0 || !$past(in_res.hex))))
        else $error("new conversion loaded without its prefix");

endmodule

FILE: design/integer_to_ascii_formatter_core.sv
// Integer to ASCII formatter: each input word (value in s_tdata, command and
// long_arg in s_tuser) becomes a run of ASCII words on the m_ side, one
// character per word, with m_tlast on the final one; command 3 produces nothing.
// Decimal conversion runs in a shift and add-3 unit that takes four bits per
// cycle, so a decimal item passes through load, 16 steps, length count and
// handoff there and a hex item only through load and handoff; the character
// emitter sends one word per cycle while m_tready allows it and takes the next
// conversion in the cycle of its last word. The input queue of FIFO_DEPTH
// entries keeps taking words while earlier ones are converted or sent.
module integer_to_ascii_formatter_core #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value
    input  logic [2:0]  s_tuser,   // command[1:0], long_arg[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_out
    output logic        m_tlast
);
    import itoa_pkg::*;

    logic  push_valid;
    job_t  push_job;
    logic  push_ready;
    logic  pop_valid;
    job_t  pop_job;
    logic  pop_ready;
    logic  conv_valid;
    conv_t conv_res;
    logic  conv_ready;

    itoa_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    itoa_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop_ready  (pop_ready)
    );

    itoa_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pop_valid),
        .in_job    (pop_job),
        .in_ready  (pop_ready),
        .out_valid (conv_valid),
        .out_res   (conv_res),
        .out_ready (conv_ready)
    );

    itoa_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (conv_valid),
        .in_res   (conv_res),
        .in_ready (conv_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
